// ===== design/ppc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants, microcode program and helpers of the perfect power classifier.
package ppc_pkg;

  // Result mask width and exponent register width
  localparam int MASK_WIDTH = 31;
  localparam int EXP_WIDTH  = 6;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;
  localparam int STEP_WIDTH = 4;

  // Register addresses (word index taken from paddr[2])
  localparam logic REG_HIGHEST_EXPONENT = 1'b0;

  localparam logic [EXP_WIDTH-1:0] HEXP_RESET = EXP_WIDTH'(2);

  typedef logic [STEP_WIDTH-1:0] step_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_CLASS = 4'd1,
    OP_RANGE = 4'd2,
    OP_MID   = 4'd3,
    OP_MULA  = 4'd4,
    OP_SATA  = 4'd5,
    OP_MULS  = 4'd6,
    OP_SATS  = 4'd7,
    OP_BELOW = 4'd8,
    OP_ABOVE = 4'd9,
    OP_HIT   = 4'd10,
    OP_NEXTE = 4'd11,
    OP_EMIT  = 4'd12
  } op_t;

  // Jump conditions
  typedef enum logic [3:0] {
    C_NEVER   = 4'd0,
    C_ALWAYS  = 4'd1,
    C_NOSTART = 4'd2,
    C_TRIVIAL = 4'd3,
    C_EOUT    = 4'd4,
    C_EMPTY   = 4'd5,
    C_ABOVE   = 4'd6,
    C_EDONE   = 4'd7,
    C_EQ      = 4'd8,
    C_OUTBUSY = 4'd9
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    op_t op;
  } ctrl_t;

  typedef struct packed {
    logic trivial;
    logic eout;
    logic empty;
    logic above;
    logic edone;
    logic eq;
    logic outbusy;
  } status_t;

  // Program addresses
  localparam step_t S_IDLE  = 4'd0;
  localparam step_t S_CLASS = 4'd1;
  localparam step_t S_ECHK  = 4'd2;
  localparam step_t S_MID   = 4'd3;
  localparam step_t S_MULA  = 4'd4;
  localparam step_t S_SATA  = 4'd5;
  localparam step_t S_TSTA  = 4'd6;
  localparam step_t S_TEND  = 4'd7;
  localparam step_t S_MULS  = 4'd8;
  localparam step_t S_SATS  = 4'd9;
  localparam step_t S_FINAL = 4'd10;
  localparam step_t S_BELOW = 4'd11;
  localparam step_t S_ABOVE = 4'd12;
  localparam step_t S_HIT   = 4'd13;
  localparam step_t S_NEXTE = 4'd14;
  localparam step_t S_DONE  = 4'd15;

  // Microcode ROM: one control word per step
  function automatic uword_t ucode(input step_t pc);
    uword_t w;
    w = '{op: OP_NONE, cond: C_NEVER, target: S_IDLE};
    case (pc)
      S_IDLE:  w = '{op: OP_NONE,  cond: C_NOSTART, target: S_IDLE};
      S_CLASS: w = '{op: OP_CLASS, cond: C_TRIVIAL, target: S_DONE};
      S_ECHK:  w = '{op: OP_RANGE, cond: C_EOUT,    target: S_DONE};
      S_MID:   w = '{op: OP_MID,   cond: C_EMPTY,   target: S_NEXTE};
      S_MULA:  w = '{op: OP_MULA,  cond: C_NEVER,   target: S_IDLE};
      S_SATA:  w = '{op: OP_SATA,  cond: C_NEVER,   target: S_IDLE};
      S_TSTA:  w = '{op: OP_NONE,  cond: C_ABOVE,   target: S_ABOVE};
      S_TEND:  w = '{op: OP_NONE,  cond: C_EDONE,   target: S_FINAL};
      S_MULS:  w = '{op: OP_MULS,  cond: C_NEVER,   target: S_IDLE};
      S_SATS:  w = '{op: OP_SATS,  cond: C_ALWAYS,  target: S_MULA};
      S_FINAL: w = '{op: OP_NONE,  cond: C_EQ,      target: S_HIT};
      S_BELOW: w = '{op: OP_BELOW, cond: C_ALWAYS,  target: S_MID};
      S_ABOVE: w = '{op: OP_ABOVE, cond: C_ALWAYS,  target: S_MID};
      S_HIT:   w = '{op: OP_HIT,   cond: C_NEVER,   target: S_IDLE};
      S_NEXTE: w = '{op: OP_NEXTE, cond: C_ALWAYS,  target: S_ECHK};
      S_DONE:  w = '{op: OP_EMIT,  cond: C_OUTBUSY, target: S_DONE};
      default: w = '{op: OP_NONE,  cond: C_NEVER,   target: S_IDLE};
    endcase
    return w;
  endfunction

  // Bits 0 .. top-2 set; none when top is below two
  function automatic logic [MASK_WIDTH-1:0] low_ones(input logic [EXP_WIDTH-1:0] top);
    logic [32:0] t;
    t = '0;
    if (top >= EXP_WIDTH'(2)) begin
      t = (33'd1 << (top - EXP_WIDTH'(1))) - 33'd1;
    end
    return t[MASK_WIDTH-1:0];
  endfunction

endpackage

// ===== design/ppc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input value and the result mask.
interface ppc_value_if #(parameter int VALUE_WIDTH = 31);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface ppc_mask_if;
  import ppc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [MASK_WIDTH-1:0] power_mask;

  modport source (output valid, output power_mask, input ready);
  modport sink (input valid, input power_mask, output ready);
endinterface

// ===== design/ppc_cfg.sv =====
`timescale 1ns / 1ps
// APB register file holding the highest exponent setting.
module ppc_cfg #(
  parameter int MAX_EXPONENT = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [ppc_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [ppc_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [ppc_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                             cfg_pready,
  output logic [ppc_pkg::EXP_WIDTH-1:0]    top
);
  import ppc_pkg::*;

  logic [EXP_WIDTH-1:0] hexp_r;
  logic [EXP_WIDTH-1:0] hexp_nxt;
  logic                 wr_hit;

  assign cfg_pready = 1'b1;
  assign wr_hit = cfg_psel && cfg_penable && cfg_pwrite
                  && (cfg_paddr[2] == REG_HIGHEST_EXPONENT);

  // Capture the register on the access phase
  always_comb begin
    hexp_nxt = hexp_r;
    if (wr_hit) begin
      hexp_nxt = cfg_pwdata[EXP_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hexp_r <= HEXP_RESET;
    end else begin
      hexp_r <= hexp_nxt;
    end
  end

  // Read back
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_HIGHEST_EXPONENT) begin
      cfg_prdata = {{(CFG_DW-EXP_WIDTH){1'b0}}, hexp_r};
    end
  end

  // Clamp to the largest supported exponent
  assign top = (hexp_r > EXP_WIDTH'(MAX_EXPONENT)) ? EXP_WIDTH'(MAX_EXPONENT) : hexp_r;

endmodule

// ===== design/ppc_sequencer.sv =====
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control ROM and conditional jumps.
module ppc_sequencer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ppc_pkg::status_t status,
  output ppc_pkg::ctrl_t   ctrl
);
  import ppc_pkg::*;

  step_t  pc_r;
  step_t  pc_nxt;
  uword_t word;
  logic   take;

  assign word     = ucode(pc_r);
  assign ctrl.op  = word.op;
  assign in_ready = (pc_r == S_IDLE);

  // Evaluate the jump condition of the current step
  always_comb begin
    case (word.cond)
      C_NEVER:   take = 1'b0;
      C_ALWAYS:  take = 1'b1;
      C_NOSTART: take = !in_valid;
      C_TRIVIAL: take = status.trivial;
      C_EOUT:    take = status.eout;
      C_EMPTY:   take = status.empty;
      C_ABOVE:   take = status.above;
      C_EDONE:   take = status.edone;
      C_EQ:      take = status.eq;
      C_OUTBUSY: take = status.outbusy;
      default:   take = 1'b0;
    endcase
  end

  // Jump or advance; the last step wraps back to idle
  assign pc_nxt = take ? word.target : (pc_r + STEP_WIDTH'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== design/ppc_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: search bounds, shared saturating multiplier, result mask and output register.
module ppc_datapath #(
  parameter int VALUE_WIDTH = 31
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [VALUE_WIDTH-1:0]        value,
  input  logic [ppc_pkg::EXP_WIDTH-1:0] top,
  input  ppc_pkg::ctrl_t                ctrl,
  output ppc_pkg::status_t              status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ppc_pkg::MASK_WIDTH-1:0] out_mask
);
  import ppc_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int AW = VW + 1;          // holds the saturated value v+1
  localparam int PW = 2 * AW;
  localparam int HW = (VW + 1) / 2;    // base never exceeds 2^HW-1
  localparam int BW = HW + 1;          // lo may step one past hi
  localparam logic [BW-1:0] HI_INIT = {1'b0, {HW{1'b1}}};

  logic [VW-1:0]         v_r, v_nxt;
  logic [EXP_WIDTH-1:0]  e_r, e_nxt;
  logic [EXP_WIDTH-1:0]  ebits_r, ebits_nxt;
  logic [BW-1:0]         lo_r, lo_nxt;
  logic [BW-1:0]         hi_r, hi_nxt;
  logic [BW-1:0]         mid_r, mid_nxt;
  logic [AW-1:0]         acc_r, acc_nxt;
  logic [AW-1:0]         sq_r, sq_nxt;
  logic [PW-1:0]         prod_r, prod_nxt;
  logic [MASK_WIDTH-1:0] mask_r, mask_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [MASK_WIDTH-1:0] out_mask_r, out_mask_nxt;

  logic [AW-1:0] v_ext;
  logic [AW-1:0] v_plus1;
  logic [AW-1:0] sat_val;
  logic [AW-1:0] mul_a;
  logic [BW-1:0] mid_calc;
  logic          emit;

  assign v_ext    = {1'b0, v_r};
  assign v_plus1  = v_ext + AW'(1);
  assign mid_calc = lo_r + ((hi_r - lo_r) >> 1);
  assign mul_a    = (ctrl.op == OP_MULS) ? sq_r : acc_r;

  // Saturate the registered product just above the value
  assign sat_val = (prod_r > {{(PW-VW){1'b0}}, v_r}) ? v_plus1 : prod_r[AW-1:0];

  // Flags for the sequencer
  assign status.trivial = (v_r < VW'(2)) || (top < EXP_WIDTH'(2));
  assign status.eout    = (e_r > top) || ((v_r >> e_r) == '0);
  assign status.empty   = (lo_r > hi_r);
  assign status.above   = (acc_r > v_ext);
  assign status.edone   = (ebits_r == '0);
  assign status.eq      = (acc_r == v_ext);
  assign status.outbusy = out_valid_r && !out_ready;

  assign emit = (ctrl.op == OP_EMIT) && !status.outbusy;

  // Execute the current micro-operation
  always_comb begin
    v_nxt     = v_r;
    e_nxt     = e_r;
    ebits_nxt = ebits_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    acc_nxt   = acc_r;
    sq_nxt    = sq_r;
    prod_nxt  = prod_r;
    mask_nxt  = mask_r;
    if (load) begin
      v_nxt = value;
    end
    case (ctrl.op)
      OP_CLASS: begin
        e_nxt    = EXP_WIDTH'(2);
        mask_nxt = (v_r == VW'(1)) ? low_ones(top) : '0;
      end
      OP_RANGE: begin
        lo_nxt = BW'(1);
        hi_nxt = HI_INIT;
      end
      OP_MID: begin
        mid_nxt   = mid_calc;
        acc_nxt   = AW'(1);
        sq_nxt    = {{(AW-BW){1'b0}}, mid_calc};
        ebits_nxt = e_r;
      end
      OP_MULA, OP_MULS: begin
        prod_nxt = PW'(mul_a) * PW'(sq_r);
      end
      OP_SATA: begin
        if (ebits_r[0]) begin
          acc_nxt = sat_val;
        end
        ebits_nxt = ebits_r >> 1;
      end
      OP_SATS:  sq_nxt = sat_val;
      OP_BELOW: lo_nxt = mid_r + BW'(1);
      OP_ABOVE: hi_nxt = mid_r - BW'(1);
      OP_HIT:   mask_nxt = mask_r | (MASK_WIDTH'(1) << (e_r - EXP_WIDTH'(2)));
      OP_NEXTE: e_nxt = e_r + EXP_WIDTH'(1);
      default: begin
      end
    endcase
  end

  // Output register: hold until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_mask_nxt  = out_mask_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_mask_nxt  = mask_r;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    e_r        <= e_nxt;
    ebits_r    <= ebits_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    acc_r      <= acc_nxt;
    sq_r       <= sq_nxt;
    prod_r     <= prod_nxt;
    mask_r     <= mask_nxt;
    out_mask_r <= out_mask_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_mask  = out_mask_r;

  // The accumulator never exceeds its saturation level
  a_acc_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_SATA) |=> (acc_r <= v_plus1))
    else $error("accumulator above saturation level");

  // A hit only marks an exponent inside the enabled range
  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_HIT) |-> ((e_r >= EXP_WIDTH'(2)) && (e_r <= top)))
    else $error("hit outside the enabled exponents");

  // No mask bit beyond the enabled exponents reaches the output
  a_mask_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_EMIT) |-> ((mask_r & ~low_ones(top)) == '0))
    else $error("mask bit above the highest exponent");

  // A new result appears only from the emit step
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.op == OP_EMIT))
    else $error("result raised outside the emit step");

endmodule

// ===== design/perfect_power_classifier.sv =====
`timescale 1ns / 1ps
// Top level of the perfect power classifier.
//
// Each transaction on in_chan carries one unsigned value; one transaction on out_chan returns
// power_mask, whose bit k is set when the value is an exact (k+2)-th power, for exponents 2 up
// to the highest_exponent register (byte address 0, clamped to MAX_EXPONENT). Value one sets
// every enabled bit, value zero none. Items are handled one at a time by a 16-step microcode
// program driving a single saturating multiplier: for each exponent e with 2^e <= value, a
// binary search over bases 1 .. 2^ceil(VALUE_WIDTH/2)-1 takes up to ceil(VALUE_WIDTH/2)
// probes, each a square-and-multiply with early exit, plus bookkeeping per exponent.
// The next value is accepted as soon as the previous result sits in the output register.
module perfect_power_classifier #(
  parameter int MAX_EXPONENT = 32,
  parameter int VALUE_WIDTH  = 31
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ppc_value_if.sink                     in_chan,
  ppc_mask_if.source                    out_chan,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [ppc_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [ppc_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [ppc_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import ppc_pkg::*;

  logic [EXP_WIDTH-1:0] top;
  ctrl_t                ctrl;
  status_t              status;
  logic                 in_ready;
  logic                 load;

  assign in_chan.ready = in_ready;
  assign load = in_chan.valid && in_ready;

  ppc_cfg #(
    .MAX_EXPONENT (MAX_EXPONENT)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .top         (top)
  );

  ppc_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .ctrl     (ctrl)
  );

  ppc_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .value     (in_chan.value),
    .top       (top),
    .ctrl      (ctrl),
    .status    (status),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_mask  (out_chan.power_mask)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the perfect power classifier: directed and random values.
module tb;
  import ppc_pkg::*;

  localparam int MAX_EXPONENT = 32;
  localparam int VALUE_WIDTH  = 31;
  localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_WIDTH) - 64'd1;
  localparam int RANDOM_ITEMS = 300;
  localparam int PHASE_ITEMS  = 30;
  localparam int SETTLE_CYCLES = 100;
  localparam longint unsigned CYCLE_LIMIT = 64'd40_000_000;
  localparam logic [CFG_AW-1:0] HEXP_ADDR = {REG_HIGHEST_EXPONENT, 2'b00};

  logic clk;
  logic rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  ppc_value_if #(.VALUE_WIDTH(VALUE_WIDTH)) in_if ();
  ppc_mask_if out_if ();

  perfect_power_classifier #(
    .MAX_EXPONENT(MAX_EXPONENT),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_if),
    .out_chan   (out_if),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Shadow of the exponent register and pending results
  logic [EXP_WIDTH-1:0]  highest_exponent;
  logic [MASK_WIDTH-1:0] expected_masks[$];
  int unsigned in_gap_max;
  int unsigned out_stall_max;
  int unsigned mismatch_count;
  int unsigned values_sent;
  int unsigned masks_checked;
  int unsigned powers_found;
  int unsigned settings_written;
  longint unsigned cycle_count;

  // base^e, saturated to cap+1 once it passes cap
  function automatic longint unsigned sat_power(input longint unsigned base, input int unsigned e,
                                                input longint unsigned cap);
    longint unsigned acc;
    acc = 1;
    repeat (e) begin
      acc = acc * base;
      if (acc > cap) begin
        return cap + 1;
      end
    end
    return acc;
  endfunction

  // Expected power mask of one value under the given exponent setting
  function automatic logic [MASK_WIDTH-1:0] classify_value(input logic [VALUE_WIDTH-1:0] v,
                                                           input logic [EXP_WIDTH-1:0] hexp);
    longint unsigned val, lo, hi, mid, p;
    int unsigned top, e;
    logic found;
    logic [MASK_WIDTH-1:0] mask;
    val  = v;
    top  = (hexp > MAX_EXPONENT) ? MAX_EXPONENT : hexp;
    mask = '0;
    if (val == 1) begin
      for (e = 2; e <= top; e++) mask[e-2] = 1'b1;
    end else if (val != 0) begin
      for (e = 2; e <= top; e++) begin
        // no base of two or more fits once 2^e passes the value
        if ((64'd1 << e) > val) break;
        lo = 2;
        hi = 46341;
        found = 1'b0;
        while (lo <= hi && !found) begin
          mid = (lo + hi) / 2;
          p = sat_power(mid, e, val);
          if (p == val) found = 1'b1;
          else if (p < val) lo = mid + 1;
          else hi = mid - 1;
        end
        if (found) mask[e-2] = 1'b1;
      end
    end
    return mask;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d results pending", $time, cycle_count,
             expected_masks.size());
    $display("CHECK FAILED");
    $finish;
  end

  // One register transaction; call at a rising edge, leaves psel high
  task automatic reg_access(input logic wr, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] wdata, output logic [CFG_DW-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rdata = cfg_prdata;
  endtask

  // Write the exponent register, then read it back
  task automatic set_highest_exponent(input logic [EXP_WIDTH-1:0] hexp);
    logic [CFG_DW-1:0] wdata;
    logic [CFG_DW-1:0] readback;
    wdata = $urandom;
    wdata[EXP_WIDTH-1:0] = hexp;
    reg_access(1'b1, HEXP_ADDR, wdata, readback);
    highest_exponent = hexp;
    settings_written++;
    reg_access(1'b0, HEXP_ADDR, '0, readback);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (readback !== CFG_DW'(hexp)) begin
      mismatch_count++;
      $display("%0t: highest_exponent readback expected %0d actual %0h", $time, hexp, readback);
    end
  endtask

  // Offer one value; returns at its accepting edge with valid still high
  task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    expected_masks.insert(expected_masks.size(), classify_value(v, highest_exponent));
    values_sent++;
  endtask

  // Drop valid and hold until every pending result is back
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    while (expected_masks.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, compare each transaction with the oldest expectation
  initial begin
    int unsigned stall;
    logic [MASK_WIDTH-1:0] want;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      masks_checked++;
      if (expected_masks.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none actual %h", $time, out_if.power_mask);
      end else begin
        want = expected_masks.pop_front();
        if (want != 0) powers_found++;
        if (out_if.power_mask !== want) begin
          mismatch_count++;
          $display("%0t: power_mask expected %h actual %h", $time, want, out_if.power_mask);
        end
      end
    end
  end

  // Register reset value and a few plain values at the default setting
  task automatic test_reset_value();
    logic [CFG_DW-1:0] readback;
    reg_access(1'b0, HEXP_ADDR, '0, readback);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (readback !== CFG_DW'(HEXP_RESET)) begin
      mismatch_count++;
      $display("%0t: reset highest_exponent expected %0d actual %0h", $time, HEXP_RESET,
               readback);
    end
    send_value(31'd0);
    send_value(31'd1);
    send_value(31'd4);
    send_value(31'd8);
    send_value(31'd2147395600);
    send_value(31'h7FFF_FFFF);
    wait_for_results();
  endtask

  // Zero, one, two and three with every exponent enabled
  task automatic test_trivial_values();
    set_highest_exponent(6'd32);
    send_value(31'd1);
    send_value(31'd0);
    send_value(31'd2);
    send_value(31'd3);
    wait_for_results();
  endtask

  // Settings below two, above the maximum and at the field limit
  task automatic test_exponent_settings();
    set_highest_exponent(6'd0);
    send_value(31'd1);
    send_value(31'd4);
    wait_for_results();
    set_highest_exponent(6'd1);
    send_value(31'd1);
    wait_for_results();
    set_highest_exponent(6'd63);
    send_value(31'd1);
    send_value(31'd1073741824);
    wait_for_results();
    set_highest_exponent(6'd33);
    send_value(31'd1);
    wait_for_results();
  endtask

  // Large values where high exponents drop out early, no idling
  task automatic test_early_stop();
    in_gap_max    = 0;
    out_stall_max = 0;
    set_highest_exponent(6'd32);
    send_value(31'd1073741824);
    send_value(31'd1162261467);
    send_value(31'd1073741823);
    send_value(31'h7FFF_FFFF);
    send_value(31'd2147395600);
    send_value(31'd1291467969);
    wait_for_results();
  endtask

  // Phases of random settings: mostly exact powers and near misses, some random widths
  task automatic test_random_values();
    logic [EXP_WIDTH-1:0] hexp;
    logic [VALUE_WIDTH-1:0] v;
    longint unsigned lo, hi, mid, p;
    int unsigned e, kind, width, sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 5))
        0: hexp = 6'd32;
        1: hexp = EXP_WIDTH'($urandom_range(0, 63));
        default: hexp = EXP_WIDTH'($urandom_range(2, 32));
      endcase
      set_highest_exponent(hexp);
      case ($urandom_range(0, 3))
        0: begin in_gap_max = 0; out_stall_max = 0; end
        1: begin in_gap_max = 8; out_stall_max = 0; end
        2: begin in_gap_max = 0; out_stall_max = 8; end
        default: begin in_gap_max = 8; out_stall_max = 8; end
      endcase
      repeat (PHASE_ITEMS) begin
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
          e = $urandom_range(2, 30);
          // largest base whose e-th power still fits the field
          lo = 2;
          hi = 46341;
          while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (sat_power(mid, e, VALUE_MAX) <= VALUE_MAX) lo = mid;
            else hi = mid - 1;
          end
          p = sat_power($urandom_range(2, int'(lo)), e, VALUE_MAX);
          if (kind >= 60) p = kind[0] ? p + 1 : p - 1;
          v = VALUE_WIDTH'(p);
        end else begin
          width = $urandom_range(1, VALUE_WIDTH);
          v = VALUE_WIDTH'($urandom) & ((VALUE_WIDTH'(1) << width) - VALUE_WIDTH'(1));
        end
        send_value(v);
        sent++;
      end
      wait_for_results();
    end
  endtask

  // Reset, then run each test in turn
  initial begin
    rst_n       <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.value <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    highest_exponent = HEXP_RESET;
    in_gap_max       = 8;
    out_stall_max    = 8;
    mismatch_count   = 0;
    values_sent      = 0;
    masks_checked    = 0;
    powers_found     = 0;
    settings_written = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_value();
    test_trivial_values();
    test_exponent_settings();
    test_early_stop();
    test_random_values();

    // Hold a while to catch any stray result
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Classified %0d values (%0d results, %0d with a power bit) across %0d settings",
             values_sent, masks_checked, powers_found, settings_written);
    $display("Covered zero, one, exponent settings 0..63, exact powers and near misses");
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
